// File: sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the sequential list engine: field widths,
// action codes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int ACTION_W = 2;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_GET    = 2'd1,
        ACT_LOCATE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic load_ptr;
        logic shift;
        logic put;
        logic rd_get;
        logic take_value;
        logic scan;
        logic take_index;
        logic set_err;
        logic clear_count;
        logic emit;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        action_t act;
        logic    ins_ok;
        logic    get_ok;
        logic    ptr_gt_pos;
        logic    scan_more;
        logic    pend;
        logic    match;
        logic    out_busy;
    } dp_status_t;

endpackage

// File: sv/sle_if.sv
// ----------------------------------------------------------------------------
// sle_if
// Request and response channels of the sequential list engine, each with
// valid, ready and the payload.
// ----------------------------------------------------------------------------
interface sle_req_if;
    logic                              valid;
    logic                              ready;
    logic [sle_pkg::ACTION_W-1:0]      action;
    logic [sle_pkg::POS_W-1:0]         position;
    logic signed [sle_pkg::WORD_W-1:0] value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

interface sle_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic signed [sle_pkg::WORD_W-1:0] read_value;
    logic [sle_pkg::IDX_W-1:0]         found_index;
    logic [sle_pkg::CNT_W-1:0]         count;
    logic                              not_empty;

    modport source (output valid, output status, output read_value,
                    output found_index, output count, output not_empty,
                    input ready);
    modport sink   (input valid, input status, input read_value,
                    input found_index, input count, input not_empty,
                    output ready);
endinterface

// File: sv/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Controller of the list engine: sequences one request at a time through
// dispatch, shift, read, scan and result hand-off.
// ----------------------------------------------------------------------------
module sle_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  sle_pkg::dp_status_t st,
    output sle_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE,
        DISPATCH,
        INS_SHIFT,
        GET_WAIT,
        LOC_SCAN,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = DISPATCH;
                end
            end
            DISPATCH:
            begin
                case (st.act)
                    sle_pkg::ACT_INSERT:
                    begin
                        if (st.ins_ok)
                        begin
                            cmd.load_ptr = 1'b1;
                            state_next   = INS_SHIFT;
                        end
                        else
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = FINISH;
                        end
                    end
                    sle_pkg::ACT_GET:
                    begin
                        if (st.get_ok)
                        begin
                            cmd.rd_get = 1'b1;
                            state_next = GET_WAIT;
                        end
                        else
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = FINISH;
                        end
                    end
                    sle_pkg::ACT_LOCATE:
                    begin
                        state_next = LOC_SCAN;
                    end
                    default:
                    begin
                        cmd.clear_count = 1'b1;
                        state_next      = FINISH;
                    end
                endcase
            end
            INS_SHIFT:
            begin
                // last pending move written, slot at position is free
                if (!st.ptr_gt_pos && !st.pend)
                begin
                    cmd.put    = 1'b1;
                    state_next = FINISH;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            GET_WAIT:
            begin
                cmd.take_value = 1'b1;
                state_next     = FINISH;
            end
            LOC_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.pend && st.match)
                begin
                    cmd.take_index = 1'b1;
                    state_next     = FINISH;
                end
                else if (!st.pend && !st.scan_more)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = FINISH;
                end
            end
            FINISH:
            begin
                if (!st.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

endmodule

// File: sv/sle_datapath.sv
// ----------------------------------------------------------------------------
// sle_datapath
// Datapath of the list engine: list memory with registered read, entry
// count, walking pointer, result registers and the response register.
// ----------------------------------------------------------------------------
module sle_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sle_pkg::ACTION_W-1:0]      req_action,
    input  logic [sle_pkg::POS_W-1:0]         req_position,
    input  logic signed [sle_pkg::WORD_W-1:0] req_value,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic                              rsp_status,
    output logic signed [sle_pkg::WORD_W-1:0] rsp_read_value,
    output logic [sle_pkg::IDX_W-1:0]         rsp_found_index,
    output logic [sle_pkg::CNT_W-1:0]         rsp_count,
    output logic                              rsp_not_empty,
    input  sle_pkg::ctrl_cmd_t                cmd,
    output sle_pkg::dp_status_t               st
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > sle_pkg::CNT_W) ? CW : sle_pkg::CNT_W;

    logic [sle_pkg::WORD_W-1:0] mem [CAPACITY];
    logic [sle_pkg::WORD_W-1:0] rd_data_reg;

    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [sle_pkg::WORD_W-1:0] wr_data;

    sle_pkg::action_t           act_reg;
    logic [sle_pkg::POS_W-1:0]  pos_reg;
    logic [sle_pkg::WORD_W-1:0] value_reg;
    logic [CW-1:0]              ptr_reg;
    logic [CW-1:0]              ptr_next;
    logic                       pend_reg;
    logic [CW-1:0]              count_reg;
    logic [AW-1:0]              hit_addr_reg;

    logic                       res_status_reg;
    logic [sle_pkg::WORD_W-1:0] res_value_reg;
    logic [AW-1:0]              res_index_reg;

    logic                       out_valid_reg;
    logic                       out_status_reg;
    logic [sle_pkg::WORD_W-1:0] out_value_reg;
    logic [sle_pkg::IDX_W-1:0]  out_index_reg;
    logic [sle_pkg::CNT_W-1:0]  out_count_reg;
    logic                       out_not_empty_reg;

    logic [EW-1:0]              pos_x;
    logic [EW-1:0]              ptr_x;
    logic [EW-1:0]              cnt_x;
    logic [EW-1:0]              pos_m1;
    logic [EW-1:0]              idx_x;
    logic [CW-1:0]              ptr_m1;
    logic [CW-1:0]              ptr_p1;
    logic                       ptr_gt_pos;
    logic                       scan_more;

    assign pos_x      = EW'(pos_reg);
    assign ptr_x      = EW'(ptr_reg);
    assign cnt_x      = EW'(count_reg);
    assign pos_m1     = pos_x - EW'(1);
    assign ptr_m1     = ptr_reg - CW'(1);
    assign ptr_p1     = ptr_reg + CW'(1);
    assign ptr_gt_pos = (ptr_x > pos_x);
    assign scan_more  = (ptr_reg < count_reg);
    assign idx_x      = EW'(res_index_reg);

    // memory port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg[AW-1:0];
        if (cmd.shift && ptr_gt_pos)
        begin
            rd_en   = 1'b1;
            rd_addr = ptr_m1[AW-1:0];
        end
        else if (cmd.rd_get)
        begin
            rd_en   = 1'b1;
            rd_addr = pos_m1[AW-1:0];
        end
        else if (cmd.scan && scan_more)
        begin
            rd_en   = 1'b1;
            rd_addr = ptr_reg[AW-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_x[AW-1:0];
        wr_data = value_reg;
        // entry read in the previous shift cycle moves up by one slot
        if (cmd.shift && pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = ptr_p1[AW-1:0];
            wr_data = rd_data_reg;
        end
        else if (cmd.put)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.capture)
        begin
            ptr_next = '0;
        end
        else if (cmd.load_ptr)
        begin
            ptr_next = count_reg;
        end
        else if (cmd.shift && ptr_gt_pos)
        begin
            ptr_next = ptr_m1;
        end
        else if (cmd.scan && scan_more)
        begin
            ptr_next = ptr_p1;
        end
    end

    // request fields and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg        <= sle_pkg::action_t'(req_action);
            pos_reg        <= req_position;
            value_reg      <= req_value;
            res_status_reg <= 1'b0;
            res_value_reg  <= '0;
            res_index_reg  <= '0;
        end
        else
        begin
            if (cmd.set_err)
            begin
                res_status_reg <= 1'b1;
            end
            if (cmd.take_value)
            begin
                res_value_reg <= rd_data_reg;
            end
            if (cmd.take_index)
            begin
                res_index_reg <= hit_addr_reg;
            end
        end
        if (cmd.scan && scan_more)
        begin
            hit_addr_reg <= ptr_reg[AW-1:0];
        end
        if (cmd.emit)
        begin
            out_status_reg    <= res_status_reg;
            out_value_reg     <= res_value_reg;
            out_index_reg     <= idx_x[sle_pkg::IDX_W-1:0];
            out_count_reg     <= cnt_x[sle_pkg::CNT_W-1:0];
            out_not_empty_reg <= (count_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.capture)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.shift)
            begin
                pend_reg <= ptr_gt_pos;
            end
            else if (cmd.scan)
            begin
                pend_reg <= scan_more;
            end
            if (cmd.put)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.clear_count)
            begin
                count_reg <= '0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.act        = act_reg;
    assign st.ins_ok     = (count_reg < CW'(CAPACITY)) && (pos_x <= cnt_x);
    assign st.get_ok     = (pos_x != '0) && (pos_x <= cnt_x);
    assign st.ptr_gt_pos = ptr_gt_pos;
    assign st.scan_more  = scan_more;
    assign st.pend       = pend_reg;
    assign st.match      = (rd_data_reg == value_reg);
    assign st.out_busy   = out_valid_reg && !rsp_ready;

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_read_value  = out_value_reg;
    assign rsp_found_index = out_index_reg;
    assign rsp_count       = out_count_reg;
    assign rsp_not_empty   = out_not_empty_reg;

endmodule

// File: sv/sequential_list_engine_core.sv
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// Ordered list of signed words with insert, get, locate and clear requests.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives one response. The list sits in a
// single memory with one write and one registered read per cycle. An insert
// moves each entry from the end down to its position up by one slot, one
// entry moved per cycle, and then writes the value; a get reads the entry at
// position - 1; a locate reads entries from index 0 until a match or the
// count; a clear zeroes the count; a rejected request only sets the error
// status. The response register lets a new request in while the last
// response waits to be taken; a request that is done while that response
// still waits holds in its last cycle until it is taken. The store is not
// cleared at reset; only entries below the count are ever read.
module sequential_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    sle_req_if.sink   req,
    sle_rsp_if.source rsp
);

    sle_pkg::ctrl_cmd_t  cmd;
    sle_pkg::dp_status_t st;

    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_action      (req.action),
        .req_position    (req.position),
        .req_value       (req.value),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_status      (rsp.status),
        .rsp_read_value  (rsp.read_value),
        .rsp_found_index (rsp.found_index),
        .rsp_count       (rsp.count),
        .rsp_not_empty   (rsp.not_empty),
        .cmd             (cmd),
        .st              (st)
    );

endmodule
